// ===== rtl/walsh_hadamard_transform_top_defines.svh =====
// Assertion macros for the Walsh-Hadamard transform block
`ifndef WALSH_HADAMARD_TRANSFORM_TOP_DEFINES_SVH
`define WALSH_HADAMARD_TRANSFORM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WHT_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("property violated");
`define WHT_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("property violated");
`else
`define WHT_ASSERT_IMP(lbl, ant, cons)
`define WHT_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

// ===== rtl/wht_pkg.sv =====
// Shared constants, types and helpers of the Walsh-Hadamard transform block
package wht_pkg;

  localparam int MAX_LOG_N    = 6;
  localparam int SAMPLE_WIDTH = 32;
  localparam int MAX_N        = 1 << MAX_LOG_N;
  localparam int DATA_W       = SAMPLE_WIDTH + MAX_LOG_N;
  localparam int COEFF_W      = DATA_W + 1;
  localparam int IDX_W        = MAX_LOG_N;
  localparam int CNT_W        = MAX_LOG_N + 1;
  localparam int LG_W         = $clog2(MAX_LOG_N + 1);
  localparam int HALF_W       = (MAX_LOG_N > 1) ? MAX_LOG_N - 1 : 1;
  localparam int BANK_DEPTH   = MAX_N / 2;
  localparam int BANK_AW      = (MAX_LOG_N > 1) ? MAX_LOG_N - 1 : 1;

  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 1'd1;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'((MAX_LOG_N < 6) ? MAX_LOG_N : 6);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [BANK_AW-1:0]       bank_addr_t;

  function automatic bank_addr_t bank_addr(input idx_t idx);
    return BANK_AW'(idx >> 1);
  endfunction

endpackage

// ===== rtl/wht_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module wht_ram #(
  parameter int   WIDTH = 8,
  parameter int   DEPTH = 2,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/walsh_hadamard_transform_top.sv =====
// Walsh-Hadamard transform: N = 2^lg samples per frame, two parity banks, one butterfly a cycle.
// Load: one sample per cycle; busy stays low until the last sample of the frame is accepted.
// Transform: lg passes of N/2 butterflies, each pass followed by a drain state.
// Output: after the last pass, coefficients in index order, one per cycle.
// Frames do not overlap: a new frame loads only after its last coefficient is read from the banks.
// Reset (synchronous, rst_n low): size 6, forward mode, empty frame; buffer contents undefined.
`include "walsh_hadamard_transform_top_defines.svh"

module walsh_hadamard_transform_top import wht_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                       out_valid,
  output logic signed [COEFF_W-1:0]  out_coeff,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_idx,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BFLY  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [CFG_W-1:0]  size_r;
  logic              inv_cfg_r;
  logic [LG_W-1:0]   xlg_r, xlg_nxt;
  logic              xinv_r, xinv_nxt;
  logic [LG_W-1:0]   stage_r, stage_nxt;
  logic [HALF_W-1:0] bf_r, bf_nxt;
  idx_t              emit_r, emit_nxt;

  logic              bf_vld_r, bf_vld_nxt;
  idx_t              bf_u_r, bf_v_r;
  logic              em_vld_r, em_vld_nxt;
  logic              em_last_r, em_last_nxt;
  logic              em_bank_r;

  logic              out_valid_r;
  logic signed [COEFF_W-1:0] out_coeff_r, out_coeff_nxt;
  logic              out_last_r;

  logic [LG_W-1:0]   eff_lg;
  logic [CNT_W-1:0]  eff_n;
  idx_t              ld_idx;
  logic [CNT_W-1:0]  ld_cnt1;
  logic              ld_fire, ld_done;

  logic [CNT_W-1:0]  n_cnt;
  idx_t              last_idx;
  logic              bf_last, stage_last;
  idx_t              bf_x, lo_mask, half_bit, bf_u_idx, bf_v_idx;

  logic [1:0]        ram_we;
  bank_addr_t        ram_wa [2];
  bank_addr_t        ram_ra [2];
  data_t             ram_wd [2];
  data_t             ram_rd [2];

  data_t             u_val, v_val, bf_sum, bf_diff;
  data_t             em_data, em_bias, em_adj, em_quo;

  // frame length from config
  always_comb begin
    eff_lg  = (int'(size_r) > MAX_LOG_N) ? LG_W'(MAX_LOG_N) : LG_W'(size_r);
    eff_n   = CNT_W'(1) << eff_lg;
    ld_fire = start && !busy;
    ld_idx  = (load_cnt_r >= eff_n) ? '0 : IDX_W'(load_cnt_r);
    ld_cnt1 = CNT_W'(ld_idx) + CNT_W'(1);
    ld_done = (ld_cnt1 == eff_n);
  end

  // butterfly indexing for the current pass
  always_comb begin
    n_cnt      = CNT_W'(1) << xlg_r;
    last_idx   = IDX_W'(n_cnt - CNT_W'(1));
    bf_last    = (CNT_W'(bf_r) == ((n_cnt >> 1) - CNT_W'(1)));
    stage_last = (stage_r == (xlg_r - LG_W'(1)));
    bf_x       = IDX_W'(bf_r);
    half_bit   = IDX_W'(1) << stage_r;
    lo_mask    = half_bit - IDX_W'(1);
    bf_u_idx   = ((bf_x & ~lo_mask) << 1) | (bf_x & lo_mask);
    bf_v_idx   = bf_u_idx | half_bit;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    xlg_nxt      = xlg_r;
    xinv_nxt     = xinv_r;
    stage_nxt    = stage_r;
    bf_nxt       = bf_r;
    emit_nxt     = emit_r;
    bf_vld_nxt   = 1'b0;
    em_vld_nxt   = 1'b0;
    em_last_nxt  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (ld_fire) begin
          load_cnt_nxt = ld_done ? '0 : ld_cnt1;
          if (ld_done) begin
            xlg_nxt   = eff_lg;
            xinv_nxt  = inv_cfg_r;
            stage_nxt = '0;
            bf_nxt    = '0;
            emit_nxt  = '0;
            state_nxt = (eff_lg == '0) ? ST_EMIT : ST_BFLY;
          end
        end
      end
      ST_BFLY: begin
        bf_vld_nxt = 1'b1;
        if (bf_last) begin
          bf_nxt    = '0;
          state_nxt = ST_DRAIN;
        end else begin
          bf_nxt = bf_r + HALF_W'(1);
        end
      end
      ST_DRAIN: begin
        if (stage_last) begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          stage_nxt = stage_r + LG_W'(1);
          state_nxt = ST_BFLY;
        end
      end
      ST_EMIT: begin
        em_vld_nxt  = 1'b1;
        em_last_nxt = (emit_r == last_idx);
        if (emit_r == last_idx) begin
          state_nxt = ST_IDLE;
        end else begin
          emit_nxt = emit_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we && (cfg_idx == REG_SIZE_LOG2)) begin
      load_cnt_nxt = '0;
    end
  end

  // memory ports
  always_comb begin
    u_val   = (^bf_u_r) ? ram_rd[1] : ram_rd[0];
    v_val   = (^bf_u_r) ? ram_rd[0] : ram_rd[1];
    bf_sum  = u_val + v_val;
    bf_diff = u_val - v_val;

    ram_we    = '0;
    ram_wa[0] = '0;
    ram_wa[1] = '0;
    ram_wd[0] = '0;
    ram_wd[1] = '0;
    if (bf_vld_r) begin
      ram_we                = 2'b11;
      ram_wa[^bf_u_r]       = bank_addr(bf_u_r);
      ram_wd[^bf_u_r]       = bf_sum;
      ram_wa[~(^bf_u_r)]    = bank_addr(bf_v_r);
      ram_wd[~(^bf_u_r)]    = bf_diff;
    end else if (ld_fire) begin
      ram_we[^ld_idx] = 1'b1;
      ram_wa[^ld_idx] = bank_addr(ld_idx);
      ram_wd[^ld_idx] = DATA_W'(in_sample);
    end

    ram_ra[0] = '0;
    ram_ra[1] = '0;
    if (state_r == ST_BFLY) begin
      ram_ra[^bf_u_idx]    = bank_addr(bf_u_idx);
      ram_ra[~(^bf_u_idx)] = bank_addr(bf_v_idx);
    end else if (state_r == ST_EMIT) begin
      ram_ra[0] = bank_addr(emit_r);
      ram_ra[1] = bank_addr(emit_r);
    end
  end

  // inverse scaling, truncate toward zero
  always_comb begin
    em_data       = em_bank_r ? ram_rd[1] : ram_rd[0];
    em_bias       = (xinv_r && em_data[DATA_W-1]) ? data_t'(n_cnt - CNT_W'(1)) : '0;
    em_adj        = em_data + em_bias;
    em_quo        = xinv_r ? (em_adj >>> xlg_r) : em_data;
    out_coeff_nxt = COEFF_W'(em_quo);
  end

  wht_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (ram_we[0]),
    .waddr (ram_wa[0]),
    .wdata (ram_wd[0]),
    .raddr (ram_ra[0]),
    .rdata (ram_rd[0])
  );

  wht_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (ram_we[1]),
    .waddr (ram_wa[1]),
    .wdata (ram_wd[1]),
    .raddr (ram_ra[1]),
    .rdata (ram_rd[1])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_cnt_r  <= '0;
      size_r      <= SIZE_RESET;
      inv_cfg_r   <= 1'b0;
      bf_vld_r    <= 1'b0;
      em_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      bf_vld_r    <= bf_vld_nxt;
      em_vld_r    <= em_vld_nxt;
      out_valid_r <= em_vld_r;
      if (cfg_we && (cfg_idx == REG_SIZE_LOG2)) begin
        size_r <= cfg_data;
      end
      if (cfg_we && (cfg_idx == REG_INVERT)) begin
        inv_cfg_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    xlg_r       <= xlg_nxt;
    xinv_r      <= xinv_nxt;
    stage_r     <= stage_nxt;
    bf_r        <= bf_nxt;
    emit_r      <= emit_nxt;
    bf_u_r      <= bf_u_idx;
    bf_v_r      <= bf_v_idx;
    em_last_r   <= em_last_nxt;
    em_bank_r   <= ^emit_r;
    out_coeff_r <= out_coeff_nxt;
    out_last_r  <= em_last_r;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_coeff = out_coeff_r;
  assign out_last  = out_last_r;

  `WHT_ASSERT_IMP(a_bank_split, state_r == ST_BFLY, (^bf_u_idx) != (^bf_v_idx))
  `WHT_ASSERT_NXT(a_frame_busy, ld_fire && ld_done, busy)
  `WHT_ASSERT_IMP(a_no_load_in_pass, bf_vld_r, !ld_fire)
  `WHT_ASSERT_NXT(a_last_gap, out_valid && out_last, !out_valid)

endmodule
